FILE: sv/mbt_pkg.sv
`default_nettype none

package mbt_pkg;

	localparam int unsigned ResultsMax = 3;

	typedef enum logic [1:0] {
		KIND_OPEN  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_TEXT  = 2'd2,
		KIND_ATTR  = 2'd3
	} token_kind_t;

	localparam logic [7:0] CharLt    = 8'h3C;
	localparam logic [7:0] CharSlash = 8'h2F;
	localparam logic [7:0] CharGt    = 8'h3E;
	localparam logic [7:0] CharEq    = 8'h3D;
	localparam logic [7:0] CharQuote = 8'h22;

	typedef struct packed {
		token_kind_t kind;
		logic [7:0]  char_value;
		logic        has_char;
		logic        token_end;
	} result_t;

	function automatic logic is_alnum(input logic [7:0] c);
		is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
			|| (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic result_t mk_char(input token_kind_t kind, input logic [7:0] c);
		result_t r;
		r.kind       = kind;
		r.char_value = c;
		r.has_char   = 1'b1;
		r.token_end  = 1'b0;
		mk_char = r;
	endfunction

	function automatic result_t mk_end(input token_kind_t kind);
		result_t r;
		r.kind       = kind;
		r.char_value = 8'h00;
		r.has_char   = 1'b0;
		r.token_end  = 1'b1;
		mk_end = r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/markup_byte_tokenizer_unit.sv
`default_nettype none

// Markup tokenizer: takes one byte of markup text per request and returns, one per
// token handshake, the bytes it keeps tagged with their token kind (open tag name,
// close tag name, text, attribute), plus an end marker after each token. A byte
// causes zero to three results; last_result flags the final one of each byte, and
// end_of_input closes any pending token and returns the scanner to text mode. A
// byte is held in the input register until the result buffer is empty or its last
// result is taken, then the mode machine forms its results in a single pass into a
// three-entry result buffer, which drains one per cycle while token_ready is high.
// Throughput is one byte per cycle for bytes with at most one result as long as
// token_ready is high. A byte passes the input register, then the result buffer.
module markup_byte_tokenizer_unit
	import mbt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       end_of_input,
	output logic            token_valid,
	input  wire logic       token_ready,
	output logic [1:0]      token_kind,
	output logic [7:0]      char_value,
	output logic            has_char,
	output logic            token_end,
	output logic            last_result
);

	typedef enum logic [3:0] {
		M_TEXT        = 4'd0,
		M_LT          = 4'd1,
		M_CLOSE_NAME  = 4'd2,
		M_CLOSE_SKIP  = 4'd3,
		M_OPEN_NAME   = 4'd4,
		M_ATTR_WS     = 4'd5,
		M_ATTR_KEY    = 4'd6,
		M_ATTR_EQ     = 4'd7,
		M_ATTR_QUOTED = 4'd8
	} mode_t;

	mode_t      mode_q, mode_nx;
	logic       pend_q, pend_nx;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	result_t    res_q [ResultsMax];
	result_t    res_nx [ResultsMax];
	logic [1:0] cnt_q, idx_q, n;

	logic       tb_emit;
	mode_t      tb_mode;
	logic       buf_empty, out_fire, last_out, move;

	assign buf_empty   = (idx_q == cnt_q);
	assign token_valid = !buf_empty;
	assign out_fire    = token_valid && token_ready;
	assign last_out    = (idx_q == cnt_q - 2'd1);
	assign move        = valid_s1 && (buf_empty || (out_fire && last_out));
	assign byte_ready  = !valid_s1 || move;

	assign token_kind  = res_q[idx_q].kind;
	assign char_value  = res_q[idx_q].char_value;
	assign has_char    = res_q[idx_q].has_char;
	assign token_end   = res_q[idx_q].token_end;
	assign last_result = last_out;

	// byte inside a tag with no attribute byte held
	always_comb begin
		tb_emit = 1'b0;
		if (byte_s1 == CharGt) begin
			tb_mode = M_TEXT;
		end else if (is_space(byte_s1)) begin
			tb_mode = M_ATTR_WS;
		end else if (byte_s1 == CharEq) begin
			tb_emit = 1'b1;
			tb_mode = M_ATTR_EQ;
		end else begin
			tb_emit = 1'b1;
			tb_mode = M_ATTR_KEY;
		end
	end

	always_comb begin
		mode_nx = mode_q;
		pend_nx = pend_q;
		n       = 2'd0;
		for (int i = 0; i < ResultsMax; i++) begin
			res_nx[i] = '0;
		end
		case (mode_q)
			M_LT: begin
				if (byte_s1 == CharSlash) begin
					mode_nx = M_CLOSE_NAME;
				end else if (is_alnum(byte_s1)) begin
					res_nx[n] = mk_char(KIND_OPEN, byte_s1);
					n = n + 2'd1;
					mode_nx = M_OPEN_NAME;
				end else begin
					res_nx[n] = mk_end(KIND_OPEN);
					n = n + 2'd1;
					if (tb_emit) begin
						res_nx[n] = mk_char(KIND_ATTR, byte_s1);
						n = n + 2'd1;
					end
					mode_nx = tb_mode;
				end
			end
			M_CLOSE_NAME: begin
				if (is_alnum(byte_s1)) begin
					res_nx[n] = mk_char(KIND_CLOSE, byte_s1);
					n = n + 2'd1;
				end else begin
					res_nx[n] = mk_end(KIND_CLOSE);
					n = n + 2'd1;
					mode_nx = (byte_s1 == CharGt) ? M_TEXT : M_CLOSE_SKIP;
				end
			end
			M_CLOSE_SKIP: begin
				if (byte_s1 == CharGt) begin
					mode_nx = M_TEXT;
				end
			end
			M_OPEN_NAME: begin
				if (is_alnum(byte_s1)) begin
					res_nx[n] = mk_char(KIND_OPEN, byte_s1);
					n = n + 2'd1;
				end else begin
					res_nx[n] = mk_end(KIND_OPEN);
					n = n + 2'd1;
					if (tb_emit) begin
						res_nx[n] = mk_char(KIND_ATTR, byte_s1);
						n = n + 2'd1;
					end
					mode_nx = tb_mode;
				end
			end
			M_ATTR_WS: begin
				if (tb_emit) begin
					res_nx[n] = mk_char(KIND_ATTR, byte_s1);
					n = n + 2'd1;
				end
				mode_nx = tb_mode;
			end
			M_ATTR_KEY: begin
				if (byte_s1 == CharGt) begin
					res_nx[n] = mk_end(KIND_ATTR);
					n = n + 2'd1;
					mode_nx = M_TEXT;
				end else begin
					res_nx[n] = mk_char(KIND_ATTR, byte_s1);
					n = n + 2'd1;
					if (byte_s1 == CharEq) begin
						mode_nx = M_ATTR_EQ;
					end
				end
			end
			M_ATTR_EQ: begin
				if (byte_s1 == CharQuote) begin
					res_nx[n] = mk_char(KIND_ATTR, byte_s1);
					n = n + 2'd1;
					mode_nx = M_ATTR_QUOTED;
				end else begin
					res_nx[n] = mk_end(KIND_ATTR);
					n = n + 2'd1;
					if (tb_emit) begin
						res_nx[n] = mk_char(KIND_ATTR, byte_s1);
						n = n + 2'd1;
					end
					mode_nx = tb_mode;
				end
			end
			M_ATTR_QUOTED: begin
				res_nx[n] = mk_char(KIND_ATTR, byte_s1);
				n = n + 2'd1;
				if (byte_s1 == CharQuote) begin
					res_nx[n] = mk_end(KIND_ATTR);
					n = n + 2'd1;
					mode_nx = M_ATTR_WS;
				end
			end
			default: begin
				if (byte_s1 == CharLt) begin
					if (pend_q) begin
						res_nx[n] = mk_end(KIND_TEXT);
						n = n + 2'd1;
					end
					pend_nx = 1'b0;
					mode_nx = M_LT;
				end else begin
					res_nx[n] = mk_char(KIND_TEXT, byte_s1);
					n = n + 2'd1;
					pend_nx = 1'b1;
					mode_nx = M_TEXT;
				end
			end
		endcase

		// close whatever token is open at end of input
		if (eoi_s1) begin
			case (mode_nx)
				M_LT, M_OPEN_NAME: begin
					res_nx[n] = mk_end(KIND_OPEN);
					n = n + 2'd1;
				end
				M_CLOSE_NAME: begin
					res_nx[n] = mk_end(KIND_CLOSE);
					n = n + 2'd1;
				end
				M_ATTR_KEY, M_ATTR_EQ, M_ATTR_QUOTED: begin
					res_nx[n] = mk_end(KIND_ATTR);
					n = n + 2'd1;
				end
				M_CLOSE_SKIP, M_ATTR_WS: begin
				end
				default: begin
					if (pend_nx) begin
						res_nx[n] = mk_end(KIND_TEXT);
						n = n + 2'd1;
					end
				end
			endcase
			mode_nx = M_TEXT;
			pend_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_TEXT;
			pend_q   <= 1'b0;
			valid_s1 <= 1'b0;
			byte_s1  <= 8'h00;
			eoi_s1   <= 1'b0;
			cnt_q    <= 2'd0;
			idx_q    <= 2'd0;
			for (int i = 0; i < ResultsMax; i++) begin
				res_q[i] <= '0;
			end
		end else begin
			if (byte_valid && byte_ready) begin
				valid_s1 <= 1'b1;
				byte_s1  <= byte_value;
				eoi_s1   <= end_of_input;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				mode_q <= mode_nx;
				pend_q <= pend_nx;
				cnt_q  <= n;
				idx_q  <= 2'd0;
				for (int i = 0; i < ResultsMax; i++) begin
					res_q[i] <= res_nx[i];
				end
			end else if (out_fire) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: test/markup_byte_tokenizer_unit_tb.sv
`default_nettype none

module markup_byte_tokenizer_unit_tb;
	import mbt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} markup_item_t;

	typedef struct {
		token_kind_t kind;
		logic [7:0]  char_value;
		logic        has_char;
		logic        token_end;
		logic        last_result;
	} token_rec_t;

	typedef enum logic [3:0] {
		SCAN_TEXT,
		SCAN_LT,
		SCAN_CLOSE_NAME,
		SCAN_CLOSE_SKIP,
		SCAN_OPEN_NAME,
		SCAN_ATTR_GAP,
		SCAN_ATTR_KEY,
		SCAN_ATTR_EQ,
		SCAN_ATTR_QUOTED
	} scan_state_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_ready;
	logic [7:0] byte_value;
	logic       end_of_input;
	logic       token_valid;
	logic       token_ready;
	logic [1:0] token_kind;
	logic [7:0] char_value;
	logic       has_char;
	logic       token_end;
	logic       last_result;

	markup_item_t pending_bytes[$];
	token_rec_t   expected_tokens[$];
	token_rec_t   byte_tokens[$];

	scan_state_t scan_state;
	bit          text_open;

	bit          byte_taken;
	bit          byte_busy;
	bit          token_taken;
	bit          tx_burst;
	bit          rx_burst;
	int unsigned byte_gap;
	int unsigned token_stall;
	int unsigned fail_count;

	markup_byte_tokenizer_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_value  (byte_value),
		.end_of_input(end_of_input),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_kind  (token_kind),
		.char_value  (char_value),
		.has_char    (has_char),
		.token_end   (token_end),
		.last_result (last_result)
	);

	always #4 clk = ~clk;

	function automatic bit letter_or_digit(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit blank_byte(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic void emit_char(token_kind_t kind, logic [7:0] c);
		token_rec_t r;
		r.kind        = kind;
		r.char_value  = c;
		r.has_char    = 1'b1;
		r.token_end   = 1'b0;
		r.last_result = 1'b0;
		byte_tokens.insert(byte_tokens.size(), r);
	endfunction

	function automatic void emit_end(token_kind_t kind);
		token_rec_t r;
		r.kind        = kind;
		r.char_value  = 8'h00;
		r.has_char    = 1'b0;
		r.token_end   = 1'b1;
		r.last_result = 1'b0;
		byte_tokens.insert(byte_tokens.size(), r);
	endfunction

	// byte inside a tag with no attribute byte held
	function automatic void enter_tag_body(logic [7:0] c);
		if (c == CharGt) begin
			scan_state = SCAN_TEXT;
		end else if (blank_byte(c)) begin
			scan_state = SCAN_ATTR_GAP;
		end else begin
			emit_char(KIND_ATTR, c);
			scan_state = (c == CharEq) ? SCAN_ATTR_EQ : SCAN_ATTR_KEY;
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, logic last);
		byte_tokens.delete();
		case (scan_state)
			SCAN_LT: begin
				if (c == CharSlash) begin
					scan_state = SCAN_CLOSE_NAME;
				end else if (letter_or_digit(c)) begin
					emit_char(KIND_OPEN, c);
					scan_state = SCAN_OPEN_NAME;
				end else begin
					emit_end(KIND_OPEN);
					enter_tag_body(c);
				end
			end
			SCAN_CLOSE_NAME: begin
				if (letter_or_digit(c)) begin
					emit_char(KIND_CLOSE, c);
				end else begin
					emit_end(KIND_CLOSE);
					scan_state = (c == CharGt) ? SCAN_TEXT : SCAN_CLOSE_SKIP;
				end
			end
			SCAN_CLOSE_SKIP: begin
				if (c == CharGt)
					scan_state = SCAN_TEXT;
			end
			SCAN_OPEN_NAME: begin
				if (letter_or_digit(c)) begin
					emit_char(KIND_OPEN, c);
				end else begin
					emit_end(KIND_OPEN);
					enter_tag_body(c);
				end
			end
			SCAN_ATTR_GAP: begin
				enter_tag_body(c);
			end
			SCAN_ATTR_KEY: begin
				if (c == CharGt) begin
					emit_end(KIND_ATTR);
					scan_state = SCAN_TEXT;
				end else begin
					emit_char(KIND_ATTR, c);
					if (c == CharEq)
						scan_state = SCAN_ATTR_EQ;
				end
			end
			SCAN_ATTR_EQ: begin
				if (c == CharQuote) begin
					emit_char(KIND_ATTR, c);
					scan_state = SCAN_ATTR_QUOTED;
				end else begin
					emit_end(KIND_ATTR);
					enter_tag_body(c);
				end
			end
			SCAN_ATTR_QUOTED: begin
				emit_char(KIND_ATTR, c);
				if (c == CharQuote) begin
					emit_end(KIND_ATTR);
					scan_state = SCAN_ATTR_GAP;
				end
			end
			default: begin
				if (c == CharLt) begin
					if (text_open)
						emit_end(KIND_TEXT);
					text_open  = 1'b0;
					scan_state = SCAN_LT;
				end else begin
					emit_char(KIND_TEXT, c);
					text_open  = 1'b1;
					scan_state = SCAN_TEXT;
				end
			end
		endcase
		if (last) begin
			case (scan_state)
				SCAN_LT, SCAN_OPEN_NAME: begin
					emit_end(KIND_OPEN);
				end
				SCAN_CLOSE_NAME: begin
					emit_end(KIND_CLOSE);
				end
				SCAN_ATTR_KEY, SCAN_ATTR_EQ, SCAN_ATTR_QUOTED: begin
					emit_end(KIND_ATTR);
				end
				SCAN_CLOSE_SKIP, SCAN_ATTR_GAP: begin
				end
				default: begin
					if (text_open)
						emit_end(KIND_TEXT);
				end
			endcase
			scan_state = SCAN_TEXT;
			text_open  = 1'b0;
		end
		if (byte_tokens.size() > 0)
			byte_tokens[$].last_result = 1'b1;
		foreach (byte_tokens[i])
			expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
	endfunction

	function automatic void push_byte(logic [7:0] c, logic last);
		markup_item_t it;
		it.value = c;
		it.last  = last;
		pending_bytes.insert(pending_bytes.size(), it);
	endfunction

	function automatic void push_text(string s, logic last);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], last && (i == s.len() - 1));
	endfunction

	function automatic logic [7:0] alnum_char();
		case ($urandom_range(0, 2))
			0: return 8'h30 + 8'($urandom_range(0, 9));
			1: return 8'h41 + 8'($urandom_range(0, 25));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [7:0] blank_char();
		int unsigned v;
		v = $urandom_range(8, 13);
		return (v == 8) ? 8'h20 : 8'(v);
	endfunction

	function automatic logic [7:0] byte_except(logic [7:0] c);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == c);
		return v;
	endfunction

	function automatic logic [7:0] markup_char();
		case ($urandom_range(0, 7))
			0: return CharLt;
			1: return CharSlash;
			2: return CharGt;
			3: return CharEq;
			4: return CharQuote;
			5: return blank_char();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 3))
			0: return byte_except(CharLt);
			1: return 8'h20;
			default: return alnum_char();
		endcase
	endfunction

	function automatic int unsigned pick_gap(bit burst);
		return burst ? 0 : $urandom_range(0, 17);
	endfunction

	// byte request side
	always @(negedge clk) begin : drive_bytes
		markup_item_t nxt;
		if (arst_n) begin
			if (byte_taken) begin
				byte_taken = 1'b0;
				byte_busy  = 1'b0;
				if ($urandom_range(0, 24) == 0)
					tx_burst = !tx_burst;
				byte_gap = pick_gap(tx_burst);
			end
			if (!byte_busy) begin
				if (byte_gap > 0) begin
					byte_gap--;
					byte_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					nxt = pending_bytes.pop_front();
					byte_valid   <= 1'b1;
					byte_value   <= nxt.value;
					end_of_input <= nxt.last;
					byte_busy     = 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// token side: stall drawn per result
	always @(negedge clk) begin
		if (arst_n) begin
			if (token_taken) begin
				token_taken = 1'b0;
				if ($urandom_range(0, 24) == 0)
					rx_burst = !rx_burst;
				token_stall = pick_gap(rx_burst);
			end
			if (token_stall > 0) begin
				token_stall--;
				token_ready <= 1'b0;
			end else begin
				token_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		token_rec_t want;
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				tokenize_byte(byte_value, end_of_input);
				byte_taken = 1'b1;
			end
			if (token_valid && token_ready) begin
				token_taken = 1'b1;
				if (expected_tokens.size() == 0) begin
					$error("unexpected result: token_kind %0d char_value %02h has_char %0b token_end %0b",
						token_kind, char_value, has_char, token_end);
					fail_count++;
				end else begin
					want = expected_tokens.pop_front();
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						fail_count++;
					end
					if (char_value !== want.char_value) begin
						$error("char_value: expected %02h, got %02h", want.char_value, char_value);
						fail_count++;
					end
					if (has_char !== want.has_char) begin
						$error("has_char: expected %0b, got %0b", want.has_char, has_char);
						fail_count++;
					end
					if (token_end !== want.token_end) begin
						$error("token_end: expected %0b, got %0b", want.token_end, token_end);
						fail_count++;
					end
					if (last_result !== want.last_result) begin
						$error("last_result: expected %0b, got %0b", want.last_result, last_result);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		byte_value   = 8'h00;
		end_of_input = 1'b0;
		token_ready  = 1'b0;
		scan_state   = SCAN_TEXT;
		text_open    = 1'b0;
		byte_busy    = 1'b0;

		// text extremes, open name, quoted value holding '>' and '<', bare value
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_text("<Z9 k=\"><\" =x>", 1'b0);
		// input ends after "</", after '<', while skipping, inside quotes
		push_text("</", 1'b1);
		push_text("<", 1'b1);
		push_text("</q ", 1'b1);
		push_text("<=\"", 1'b1);

		while (pending_bytes.size() < 380) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat ($urandom_range(1, 6))
						push_byte(text_char(), 1'b0);
				end
				3, 4, 5: begin
					push_byte(CharLt, 1'b0);
					repeat ($urandom_range(0, 4))
						push_byte(alnum_char(), 1'b0);
					repeat ($urandom_range(0, 2)) begin
						repeat ($urandom_range(1, 2))
							push_byte(blank_char(), 1'b0);
						repeat ($urandom_range(1, 4))
							push_byte(($urandom_range(0, 5) == 0) ? markup_char() : alnum_char(),
								1'b0);
						case ($urandom_range(0, 2))
							1: begin
								push_byte(CharEq, 1'b0);
								push_byte(CharQuote, 1'b0);
								repeat ($urandom_range(0, 5))
									push_byte(($urandom_range(0, 3) == 0) ? markup_char()
										: byte_except(CharQuote), 1'b0);
								push_byte(CharQuote, 1'b0);
							end
							2: begin
								push_byte(CharEq, 1'b0);
								repeat ($urandom_range(1, 3))
									push_byte(alnum_char(), 1'b0);
							end
							default: begin
							end
						endcase
					end
					if ($urandom_range(0, 2) == 0)
						push_byte(blank_char(), 1'b0);
					if ($urandom_range(0, 11) != 0)
						push_byte(CharGt, 1'b0);
				end
				6, 7: begin
					push_byte(CharLt, 1'b0);
					push_byte(CharSlash, 1'b0);
					repeat ($urandom_range(0, 4))
						push_byte(alnum_char(), 1'b0);
					if ($urandom_range(0, 2) == 0)
						repeat ($urandom_range(1, 3))
							push_byte(byte_except(CharGt), 1'b0);
					push_byte(CharGt, 1'b0);
				end
				8: begin
					repeat ($urandom_range(1, 4))
						push_byte(8'($urandom_range(0, 255)), 1'b0);
				end
				default: begin
					repeat ($urandom_range(1, 4))
						push_byte(markup_char(), 1'b0);
				end
			endcase
			if ($urandom_range(0, 9) == 0)
				pending_bytes[$].last = 1'b1;
		end
		pending_bytes[$].last = 1'b1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || byte_valid || expected_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
